>>> rtl/hash_map_key_value_store_top_defines.svh
// Assertion macros for the key-value map.
// Included by the top level; no other dependencies.
`ifndef HASH_MAP_KEY_VALUE_STORE_TOP_DEFINES_SVH
`define HASH_MAP_KEY_VALUE_STORE_TOP_DEFINES_SVH

// same-cycle implication
`define HMKV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HMKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hmkv_pkg.sv
// Shared constants for the key-value map.
// No dependencies.
package hmkv_pkg;

    localparam int BUCKETS    = 32;
    localparam int WAYS       = 4;
    localparam int KEY_BITS   = 20;
    localparam int VALUE_BITS = 20;

    localparam int CMD_BITS   = 2;
    localparam int RD_BITS    = 21;
    localparam int COUNT_BITS = 8;

    localparam logic [CMD_BITS-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd2;

endpackage

>>> rtl/hmkv_if.sv
// Request and response channels of the key-value map.
// Depends on hmkv_pkg.
interface hmkv_req_if #(
    parameter int KEY_BITS   = hmkv_pkg::KEY_BITS,
    parameter int VALUE_BITS = hmkv_pkg::VALUE_BITS
);
    logic                          valid;
    logic                          ready;
    logic [hmkv_pkg::CMD_BITS-1:0] cmd;
    logic [KEY_BITS-1:0]           key;
    logic [VALUE_BITS-1:0]         value;

    modport source (output valid, cmd, key, value, input ready);
    modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface hmkv_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   found;
    logic signed [hmkv_pkg::RD_BITS-1:0]    read_value;
    logic                                   bucket_full;
    logic [hmkv_pkg::COUNT_BITS-1:0]        entry_count;

    modport source (output valid, found, read_value, bucket_full, entry_count, input ready);
    modport sink   (input valid, found, read_value, bucket_full, entry_count, output ready);
endinterface

>>> rtl/hmkv_ram.sv
// Generic single-port RAM, read-before-write, registered read data.
// No dependencies.
module hmkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/hmkv_hash.sv
// Bucket index = key mod BUCKETS. Power-of-two bucket counts take the low
// key bits in the start cycle; others multiply by a constant reciprocal, registering the quotient, then the remainder.
// No package dependencies.
module hmkv_hash #(
    parameter int BUCKETS  = 32,
    parameter int KEY_BITS = 20
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [KEY_BITS-1:0]        i_key,
    output logic                       o_valid,
    output logic [$clog2(BUCKETS)-1:0] o_bucket
);

    localparam int  RB   = $clog2(BUCKETS);
    localparam bit  POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    generate
        if (POW2) begin : g_mask
            assign o_valid  = i_start;
            assign o_bucket = RB'(i_key);
        end else begin : g_recip
            // quotient = (key * RECIP) >> SH, exact for every KEY_BITS-bit key
            localparam int MW = KEY_BITS + 1;
            localparam int SH = KEY_BITS + RB;
            localparam int PW = KEY_BITS + MW;
            localparam logic [MW-1:0] RECIP =
                MW'(((64'd1 << SH) + 64'(BUCKETS - 1)) / 64'(BUCKETS));

            logic [KEY_BITS-1:0] r_key;
            logic [KEY_BITS-1:0] r_quo;
            logic [RB-1:0]       r_rem;
            logic                r_mul;
            logic                r_done;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mul  <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_mul  <= i_start;
                    r_done <= r_mul;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_key <= i_key;
                    r_quo <= KEY_BITS'((PW'(i_key) * PW'(RECIP)) >> SH);
                end
                if (r_mul) begin
                    r_rem <= RB'(r_key - r_quo * KEY_BITS'(BUCKETS));
                end
            end

            assign o_valid  = r_done;
            assign o_bucket = r_rem;
        end
    endgenerate

endmodule

>>> rtl/hash_map_key_value_store_top.sv
// Key-value map: one bucket row per RAM word, read then modified and written back.
// Power-of-two BUCKETS: S_IDLE goes straight to S_MOD on acceptance; else via
// S_HASH while key mod BUCKETS is taken by a constant reciprocal multiply.
// One item at a time, ready only in S_IDLE; single RAM port: one read, one write.
// Reset: synchronous; a clearing pass zeroes every row, with ready low.
`include "hash_map_key_value_store_top_defines.svh"
module hash_map_key_value_store_top #(
    parameter int BUCKETS    = hmkv_pkg::BUCKETS,
    parameter int WAYS       = hmkv_pkg::WAYS,
    parameter int KEY_BITS   = hmkv_pkg::KEY_BITS,
    parameter int VALUE_BITS = hmkv_pkg::VALUE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hmkv_req_if.sink    i_req,
    hmkv_rsp_if.source  o_rsp
);

    localparam int RB      = $clog2(BUCKETS);
    localparam int EW      = 1 + KEY_BITS + VALUE_BITS;
    localparam int ROW_W   = WAYS * EW;
    localparam int CNT_W   = $clog2(BUCKETS * WAYS + 1);
    localparam int RD_W    = hmkv_pkg::RD_BITS;
    localparam int COUNT_W = hmkv_pkg::COUNT_BITS;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HASH  = 4'b0100,
        S_MOD   = 4'b1000
    } t_state;

    t_state                        r_state;
    logic [hmkv_pkg::CMD_BITS-1:0] r_cmd;
    logic [KEY_BITS-1:0]           r_key;
    logic [VALUE_BITS-1:0]         r_value;
    logic [RB-1:0]                 r_bucket;
    logic [RB-1:0]                 r_clr;
    logic [CNT_W-1:0]              r_count, n_count;
    logic                          r_out_valid;
    logic                          r_found, n_found;
    logic [RD_W-1:0]               r_rd, n_rd;
    logic                          r_full, n_full;

    logic             w_acc;
    logic             w_mod_go;
    logic             h_valid;
    logic [RB-1:0]    h_bucket;
    logic             ram_we;
    logic [RB-1:0]    ram_addr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] n_row;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_mod_go    = (r_state == S_MOD) && (!r_out_valid || o_rsp.ready);

    hmkv_hash #(
        .BUCKETS  (BUCKETS),
        .KEY_BITS (KEY_BITS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_acc),
        .i_key    (i_req.key),
        .o_valid  (h_valid),
        .o_bucket (h_bucket)
    );

    always_comb begin
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
            end
            S_MOD: begin
                ram_we    = w_mod_go;
                ram_addr  = r_bucket;
                ram_wdata = n_row;
            end
            default: begin
                ram_we    = 1'b0;
                ram_addr  = h_bucket;
                ram_wdata = n_row;
            end
        endcase
    end

    hmkv_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // row entry layout: {valid, key, value}
    always_comb begin
        logic [WAYS-1:0]       hit_vec, free_vec, first_hit, first_free;
        logic [EW-1:0]         ent;
        logic [VALUE_BITS-1:0] hit_val;
        hit_vec = '0;
        free_vec = '0;
        hit_val = '0;
        for (int w = 0; w < WAYS; w++) begin
            ent = ram_rdata[w*EW +: EW];
            hit_vec[w]  = ent[EW-1] && (ent[EW-2 -: KEY_BITS] == r_key);
            free_vec[w] = !ent[EW-1];
        end
        first_hit  = hit_vec & ~(hit_vec - 1'b1);
        first_free = free_vec & ~(free_vec - 1'b1);
        for (int w = 0; w < WAYS; w++) begin
            if (first_hit[w]) begin
                hit_val = ram_rdata[w*EW +: VALUE_BITS];
            end
        end

        n_row   = ram_rdata;
        n_found = |hit_vec;
        n_rd    = '1;
        n_full  = 1'b0;
        n_count = r_count;
        case (r_cmd)
            hmkv_pkg::CMD_PUT: begin
                if (|hit_vec) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (first_hit[w]) begin
                            n_row[w*EW +: VALUE_BITS] = r_value;
                        end
                    end
                end else if (|free_vec) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (first_free[w]) begin
                            n_row[w*EW +: EW] = {1'b1, r_key, r_value};
                        end
                    end
                    n_count = r_count + 1'b1;
                end else begin
                    n_full = 1'b1;
                end
            end
            hmkv_pkg::CMD_GET: begin
                if (|hit_vec) begin
                    n_rd = RD_W'(hit_val);
                end
            end
            hmkv_pkg::CMD_REMOVE: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (first_hit[w]) begin
                        n_row[w*EW + EW - 1] = 1'b0;
                    end
                end
                if ((|hit_vec) && (r_count != '0)) begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_row = ram_rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == RB'(BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= h_valid ? S_MOD : S_HASH;
                    end
                end
                S_HASH: begin
                    if (h_valid) begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (w_mod_go) begin
                        r_state     <= S_IDLE;
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_clr   <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd   <= i_req.cmd;
            r_key   <= i_req.key;
            r_value <= i_req.value;
        end
        if (h_valid) begin
            r_bucket <= h_bucket;
        end
        if (w_mod_go) begin
            r_found <= n_found;
            r_rd    <= n_rd;
            r_full  <= n_full;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_found;
    assign o_rsp.read_value  = $signed(r_rd);
    assign o_rsp.bucket_full = r_full;
    assign o_rsp.entry_count = COUNT_W'(r_count);

    `HMKV_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(BUCKETS * WAYS), "entry count exceeds capacity")
    `HMKV_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !w_mod_go, $stable(r_count), "entry count changed outside an update")
    `HMKV_ASSERT_NOW(a_full_miss, i_clk, i_rst_n, o_rsp.valid, !(o_rsp.found && o_rsp.bucket_full), "bucket full flagged on a hit")

endmodule

>>> test/hmkv_checker.sv
// Checker for the key-value map: watches the request and response channels,
// keeps its own copy of the bucket table and compares every response.
// Depends on hmkv_pkg and the channel interfaces in hmkv_if.sv.
module hmkv_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    hmkv_req_if  i_req,
    hmkv_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int DEPTH = hmkv_pkg::BUCKETS * hmkv_pkg::WAYS;
    localparam int RD_W  = hmkv_pkg::RD_BITS;
    localparam int CNT_W = hmkv_pkg::COUNT_BITS;

    typedef struct packed {
        logic                                  found;
        logic signed [hmkv_pkg::RD_BITS-1:0]   read_value;
        logic                                  bucket_full;
        logic [hmkv_pkg::COUNT_BITS-1:0]       entry_count;
    } t_map_result;

    logic                            slot_valid [DEPTH];
    logic [hmkv_pkg::KEY_BITS-1:0]   slot_key   [DEPTH];
    logic [hmkv_pkg::VALUE_BITS-1:0] slot_val   [DEPTH];
    int                              key_count;
    t_map_result                     awaited_results [$];
    int                              fails = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    // applies one request to the table copy and returns the response it causes
    function automatic t_map_result apply_request(
        input logic [hmkv_pkg::CMD_BITS-1:0]   cmd,
        input logic [hmkv_pkg::KEY_BITS-1:0]   key,
        input logic [hmkv_pkg::VALUE_BITS-1:0] value);
        int          base;
        int          hit;
        int          free_slot;
        t_map_result res;
        base      = int'(key % hmkv_pkg::BUCKETS) * hmkv_pkg::WAYS;
        hit       = -1;
        free_slot = -1;
        for (int w = 0; w < hmkv_pkg::WAYS; w++) begin
            if (slot_valid[base + w]) begin
                if (hit < 0 && slot_key[base + w] == key) hit = base + w;
            end else if (free_slot < 0) begin
                free_slot = base + w;
            end
        end
        res.found       = (hit >= 0);
        res.read_value  = '1;
        res.bucket_full = 1'b0;
        case (cmd)
            hmkv_pkg::CMD_PUT: begin
                if (hit >= 0) begin
                    slot_val[hit] = value;
                end else if (free_slot >= 0) begin
                    slot_valid[free_slot] = 1'b1;
                    slot_key[free_slot]   = key;
                    slot_val[free_slot]   = value;
                    key_count++;
                end else begin
                    res.bucket_full = 1'b1;
                end
            end
            hmkv_pkg::CMD_GET: begin
                if (hit >= 0) res.read_value = RD_W'(slot_val[hit]);
            end
            hmkv_pkg::CMD_REMOVE: begin
                if (hit >= 0) begin
                    slot_valid[hit] = 1'b0;
                    if (key_count > 0) key_count--;
                end
            end
            default: ;
        endcase
        res.entry_count = CNT_W'(key_count);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_map_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_val[i]   = '0;
            end
            key_count = 0;
            awaited_results.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                awaited_results.push_back(apply_request(i_req.cmd, i_req.key, i_req.value));
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("response with no request pending", 1, 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_rsp.found !== want.found)
                        report_mismatch("found", int'(i_rsp.found), int'(want.found));
                    if (i_rsp.read_value !== want.read_value)
                        report_mismatch("read_value", int'(i_rsp.read_value),
                                        int'(want.read_value));
                    if (i_rsp.bucket_full !== want.bucket_full)
                        report_mismatch("bucket_full", int'(i_rsp.bucket_full),
                                        int'(want.bucket_full));
                    if (i_rsp.entry_count !== want.entry_count)
                        report_mismatch("entry_count", int'(i_rsp.entry_count),
                                        int'(want.entry_count));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_results.size();
    end

endmodule

>>> test/testbench.sv
// Top of the key-value map testbench: clock, reset, request stimulus and
// response back-pressure; the checker beside the block does the comparing.
// Depends on hmkv_pkg, hmkv_if.sv, hmkv_checker and hash_map_key_value_store_top.
module testbench;

    localparam int CMD_W   = hmkv_pkg::CMD_BITS;
    localparam int KEY_W   = hmkv_pkg::KEY_BITS;
    localparam int VAL_W   = hmkv_pkg::VALUE_BITS;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int HI_BITS = KEY_W - $clog2(hmkv_pkg::BUCKETS);
    localparam int PHASES  = 5;
    localparam int PHASE_ITEMS = 250;

    logic i_clk;
    logic i_rst_n;
    logic req_taken = 1'b0;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    int   fail_count;
    int   pending;

    logic [HI_BITS-1:0] hi_pool [8];

    hmkv_req_if req_ch ();
    hmkv_rsp_if rsp_ch ();

    hash_map_key_value_store_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    hmkv_checker map_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) req_taken <= req_ch.valid && req_ch.ready;

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value);
        while ($urandom_range(0, 99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= cmd;
        req_ch.key   <= key;
        req_ch.value <= value;
        @(negedge i_clk);
        while (!req_taken) @(negedge i_clk);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // most keys alias into a few buckets so that buckets fill up
    function automatic logic [KEY_W-1:0] pick_key();
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 55)
            return {hi_pool[$urandom_range(0, 7)], (KEY_W-HI_BITS)'($urandom_range(0, 7))};
        else if (mode < 90)
            return {hi_pool[$urandom_range(0, 7)],
                    (KEY_W-HI_BITS)'($urandom_range(0, hmkv_pkg::BUCKETS-1))};
        return KEY_W'($urandom);
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd(input int put_pct);
        int r;
        if ($urandom_range(0, 99) < put_pct) return hmkv_pkg::CMD_PUT;
        r = $urandom_range(0, 99);
        if (r < 55) return hmkv_pkg::CMD_GET;
        if (r < 90) return hmkv_pkg::CMD_REMOVE;
        return CMD_UNUSED;
    endfunction

    initial begin
        int phase_idle  [PHASES] = '{0, 78, 0, 34, 0};
        int phase_stall [PHASES] = '{0, 0, 78, 34, 0};
        int phase_put   [PHASES] = '{60, 45, 70, 35, 50};
        logic [KEY_W-1:0] top_b0;

        req_ch.valid = 1'b0;
        req_ch.cmd   = hmkv_pkg::CMD_PUT;
        req_ch.key   = '0;
        req_ch.value = '0;
        i_rst_n      = 1'b0;
        hi_pool[0]   = '0;
        hi_pool[7]   = '1;
        for (int i = 1; i < 7; i++) hi_pool[i] = HI_BITS'($urandom);
        top_b0 = {{HI_BITS{1'b1}}, {(KEY_W-HI_BITS){1'b0}}};

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty map, full bucket 0, updates, misses, unused command
        send_item(hmkv_pkg::CMD_GET,    '0,          '0);
        send_item(hmkv_pkg::CMD_REMOVE, '0,          '0);
        send_item(hmkv_pkg::CMD_PUT,    '0,          '0);
        send_item(hmkv_pkg::CMD_PUT,    KEY_W'(32),  '1);
        send_item(hmkv_pkg::CMD_PUT,    KEY_W'(64),  VAL_W'(5));
        send_item(hmkv_pkg::CMD_PUT,    top_b0,      VAL_W'(20'h55555));
        send_item(hmkv_pkg::CMD_PUT,    KEY_W'(96),  VAL_W'(7));
        send_item(hmkv_pkg::CMD_PUT,    KEY_W'(32),  VAL_W'(20'hAAAAA));
        send_item(hmkv_pkg::CMD_GET,    KEY_W'(32),  '0);
        send_item(hmkv_pkg::CMD_GET,    KEY_W'(96),  '0);
        send_item(hmkv_pkg::CMD_GET,    top_b0,      '1);
        send_item(CMD_UNUSED,           KEY_W'(32),  '1);
        send_item(CMD_UNUSED,           KEY_W'(96),  '0);
        send_item(hmkv_pkg::CMD_REMOVE, KEY_W'(64),  '0);
        send_item(hmkv_pkg::CMD_REMOVE, KEY_W'(64),  '0);
        send_item(hmkv_pkg::CMD_PUT,    KEY_W'(96),  VAL_W'(9));
        send_item(hmkv_pkg::CMD_GET,    KEY_W'(96),  '0);
        send_item(hmkv_pkg::CMD_PUT,    '1,          '1);
        send_item(hmkv_pkg::CMD_GET,    '1,          '0);
        send_item(hmkv_pkg::CMD_REMOVE, '1,          '0);
        send_item(hmkv_pkg::CMD_GET,    '0,          '0);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(pick_cmd(phase_put[p]), pick_key(), VAL_W'($urandom));
            wait_idle();
        end

        stall_pct = 0;
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/hmkv_pkg.sv
rtl/hmkv_if.sv
rtl/hmkv_ram.sv
rtl/hmkv_hash.sv
rtl/hash_map_key_value_store_top.sv
test/hmkv_checker.sv
test/testbench.sv
